[hdl/incubation_rate_accumulator_assert.svh]
// Assertion macros for the incubation rate accumulator.
// Included by the modules that check their own logic; no other dependencies.
`ifndef INCUBATION_RATE_ACCUMULATOR_ASSERT_SVH
`define INCUBATION_RATE_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define IRA_ASSERT_IMP(label, clock, resetn, ante, cons) \
  label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
    else $error("incubation_rate_accumulator: same-cycle check failed");
`define IRA_ASSERT_NXT(label, clock, resetn, ante, cons) \
  label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
    else $error("incubation_rate_accumulator: next-cycle check failed");
`else
`define IRA_ASSERT_IMP(label, clock, resetn, ante, cons)
`define IRA_ASSERT_NXT(label, clock, resetn, ante, cons)
`endif
`endif

[hdl/ira_pkg.sv]
// Shared types and constants of the incubation rate accumulator.
// No dependencies; used by the channel interfaces and the top level.
package ira_pkg;

  // Field widths of the channels and registers.
  localparam int TEMP_W      = 11;
  localparam int RATE_OUT_W  = 24;
  localparam int SUM_OUT_W   = 26;
  localparam int THR_W       = 26;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 4;

  localparam int FRACTION_BITS_DEFAULT = 24;

  // Polynomial datapath: Y = y * 2^40 fits a 52 bit signed word for any sample.
  localparam int ACC_W  = 52;
  localparam int YQ_SH  = 16;
  localparam int YQ_W   = ACC_W - YQ_SH;
  localparam int DIV_W  = YQ_W + 5;
  localparam int YQ_FRAC = 24;

  // Folded coefficients, rounded to nearest, scaled by 2^40.
  localparam logic signed [ACC_W-1:0] K0 = 52'sd46136607413109;
  localparam logic signed [ACC_W-1:0] K1 = 52'sd245974495029;
  localparam logic signed [ACC_W-1:0] K2 = 52'sd421035644;
  localparam logic signed [ACC_W-1:0] K3 = 52'sd143371;

  // Register reset values.
  localparam logic signed [TEMP_W-1:0] BAND_LOW_RST  = 11'sd128;
  localparam logic signed [TEMP_W-1:0] BAND_HIGH_RST = 11'sd560;
  localparam logic [THR_W-1:0]         THRESHOLD_RST = 26'd16775538;

  // Register indexes (byte address bits [3:2]).
  typedef enum logic [1:0] {
    REG_BAND_LOW  = 2'd0,
    REG_BAND_HIGH = 2'd1,
    REG_THRESHOLD = 2'd2
  } ira_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_PREP,
    S_CHK,
    S_DIV,
    S_OUT
  } ira_state_t;

endpackage

[hdl/ira_ifs.sv]
// Valid/ready channel interfaces for the incubation rate accumulator.
// Depends on ira_pkg for the field widths.
interface ira_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [ira_pkg::TEMP_W-1:0] temperature;
  logic                              start_accumulation;
  logic                              final_hour;

  modport source (output valid, output temperature, output start_accumulation,
                  output final_hour, input ready);
  modport sink   (input valid, input temperature, input start_accumulation,
                  input final_hour, output ready);
endinterface

interface ira_out_if;
  logic                             valid;
  logic                             ready;
  logic [ira_pkg::RATE_OUT_W-1:0]   hourly_rate;
  logic [ira_pkg::SUM_OUT_W-1:0]    accumulated;
  logic                             incubation_done;
  logic                             done_this_hour;
  logic                             data_ended;

  modport source (output valid, output hourly_rate, output accumulated,
                  output incubation_done, output done_this_hour, output data_ended,
                  input ready);
  modport sink   (input valid, input hourly_rate, input accumulated,
                  input incubation_done, input done_this_hour, input data_ended,
                  output ready);
endinterface

[hdl/incubation_rate_accumulator.sv]
// Incubation rate accumulator top level: sequencer, shared multiply-add unit,
// restoring divider and saturating accumulator. Depends on ira_pkg, ira_ifs and
// incubation_rate_accumulator_assert.svh.
// Each in_ch transaction (hourly temperature in 1/16 C, start mark, final-hour mark)
// yields one out_ch transaction: the rate 1/(24*y) in Q0.24, the saturating Q2.24
// sum since the last start, the latched done flag, a one-hour crossing pulse and
// the final-hour echo. The APB-style port (pready tied high) sets the band limits
// and the done threshold. The user must write it only while the block is idle.
// The block does not enforce this. A sample inside the band with positive y whose
// divisor does not saturate passes through three multiply and add rounds of
// Horner's rule on one multiplier, divisor setup and check, the restoring
// divider at one quotient bit per cycle, and the output load. Any other sample
// skips the divider. in_ch.ready is high only while the sequencer is idle, so a
// new sample is taken only after the previous result has been loaded.
// Reset (synchronous, rst_n low) clears the sum, the accumulating and done flags and the
// result valid bit, and loads the register defaults (8.0 C, 35.0 C, 0.9999).
// A stalled result waits in the output register while the sequencer holds its
// final state; the next sample is accepted once the result has been loaded.
module incubation_rate_accumulator #(
  parameter int FRACTION_BITS = ira_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ira_in_if.sink                            in_ch,
  ira_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ira_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [ira_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ira_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

`include "incubation_rate_accumulator_assert.svh"

  localparam int RATE_W = FRACTION_BITS;
  localparam int SUM_W  = FRACTION_BITS + 2;
  localparam int CMP_W  = (SUM_W > ira_pkg::THR_W) ? SUM_W : ira_pkg::THR_W;
  localparam int CNT_W  = $clog2(FRACTION_BITS);
  localparam int ACC_W  = ira_pkg::ACC_W;
  localparam int DIV_W  = ira_pkg::DIV_W;
  localparam int TEMP_W = ira_pkg::TEMP_W;

  // The divider saturates whenever 24*yq is at most 2^24; this value also seeds
  // the partial remainder, since the dividend is 2^24 followed by zero bits.
  localparam logic [DIV_W-1:0] DIV_SAT = DIV_W'(1) << ira_pkg::YQ_FRAC;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic signed [TEMP_W-1:0]       band_low_r;
  logic signed [TEMP_W-1:0]       band_high_r;
  logic [ira_pkg::THR_W-1:0]      threshold_r;
  logic                           cfg_wr;
  ira_pkg::ira_reg_t              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = ira_pkg::ira_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_low_r  <= ira_pkg::BAND_LOW_RST;
      band_high_r <= ira_pkg::BAND_HIGH_RST;
      threshold_r <= ira_pkg::THRESHOLD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ira_pkg::REG_BAND_LOW:  band_low_r  <= pwdata[TEMP_W-1:0];
        ira_pkg::REG_BAND_HIGH: band_high_r <= pwdata[TEMP_W-1:0];
        ira_pkg::REG_THRESHOLD: threshold_r <= pwdata[ira_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Reads return the signed limits sign-extended to the bus width.
  always_comb begin
    case (cfg_idx)
      ira_pkg::REG_BAND_LOW:
        prdata = {{(ira_pkg::CFG_DATA_W-TEMP_W){band_low_r[TEMP_W-1]}}, band_low_r};
      ira_pkg::REG_BAND_HIGH:
        prdata = {{(ira_pkg::CFG_DATA_W-TEMP_W){band_high_r[TEMP_W-1]}}, band_high_r};
      ira_pkg::REG_THRESHOLD:
        prdata = {{(ira_pkg::CFG_DATA_W-ira_pkg::THR_W){1'b0}}, threshold_r};
      default:
        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  ira_pkg::ira_state_t state_r, state_nxt;

  logic signed [TEMP_W-1:0] temp_r;
  logic                     start_r;
  logic                     final_r;
  logic                     in_band_r;
  logic [1:0]               step_r;
  logic [CNT_W-1:0]         cnt_r;

  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_r;
  logic [DIV_W-1:0]         div_r;
  logic [DIV_W-1:0]         rem_r;
  logic [RATE_W-1:0]        rate_r;

  logic                     out_valid_r;
  logic                     out_free;
  logic                     in_fire;
  logic                     out_load;
  logic                     y_nonpos;
  logic                     div_sat;
  logic                     last_round;
  logic                     last_bit;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign y_nonpos   = acc_r[ACC_W-1] || (acc_r == '0);
  assign div_sat    = (div_r <= DIV_SAT);
  assign last_round = (step_r == 2'd2);
  assign last_bit   = (cnt_r == CNT_W'(FRACTION_BITS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ira_pkg::S_IDLE: if (in_fire) state_nxt = ira_pkg::S_MUL;
      ira_pkg::S_MUL:  state_nxt = ira_pkg::S_ADD;
      ira_pkg::S_ADD:  state_nxt = last_round ? ira_pkg::S_PREP : ira_pkg::S_MUL;
      ira_pkg::S_PREP: state_nxt = ira_pkg::S_CHK;
      ira_pkg::S_CHK: begin
        if (!in_band_r || y_nonpos || div_sat) state_nxt = ira_pkg::S_OUT;
        else                                   state_nxt = ira_pkg::S_DIV;
      end
      ira_pkg::S_DIV:  if (last_bit) state_nxt = ira_pkg::S_OUT;
      ira_pkg::S_OUT:  if (out_free) state_nxt = ira_pkg::S_IDLE;
      default:         state_nxt = ira_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == ira_pkg::S_IDLE);
    out_load    = (state_r == ira_pkg::S_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ira_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // ---------------------------------------------------------------------------
  // Shared multiply-add unit: Y = ((-K3*t + K2)*t - K1)*t + K0, exact.
  // ---------------------------------------------------------------------------
  logic signed [ACC_W+TEMP_W-1:0] prod_full;
  logic signed [ACC_W-1:0]        coef;

  assign prod_full = (ACC_W+TEMP_W)'(acc_r) * (ACC_W+TEMP_W)'(temp_r);

  always_comb begin
    case (step_r)
      2'd0:    coef = ira_pkg::K2;
      2'd1:    coef = -ira_pkg::K1;
      2'd2:    coef = ira_pkg::K0;
      default: coef = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Restoring divider step: one quotient bit of 2^(FRACTION_BITS+24) / (24*yq).
  // ---------------------------------------------------------------------------
  localparam int YQ_W_C = ira_pkg::YQ_W;

  logic [DIV_W:0]     rem_sh;
  logic [DIV_W:0]     rem_diff;
  logic               q_bit;
  logic [YQ_W_C-1:0]  yq;

  assign rem_sh   = {rem_r, 1'b0};
  assign rem_diff = rem_sh - {1'b0, div_r};
  assign q_bit    = (rem_sh >= {1'b0, div_r});
  assign yq       = acc_r[ACC_W-1:ira_pkg::YQ_SH];

  always_ff @(posedge clk) begin
    case (state_r)
      ira_pkg::S_IDLE: begin
        if (in_fire) begin
          temp_r    <= in_ch.temperature;
          start_r   <= in_ch.start_accumulation;
          final_r   <= in_ch.final_hour;
          in_band_r <= (in_ch.temperature > band_low_r) &&
                       (in_ch.temperature < band_high_r);
          acc_r     <= -ira_pkg::K3;
          step_r    <= 2'd0;
        end
      end
      ira_pkg::S_MUL: begin
        prod_r <= prod_full[ACC_W-1:0];
      end
      ira_pkg::S_ADD: begin
        acc_r  <= prod_r + coef;
        step_r <= step_r + 2'd1;
      end
      ira_pkg::S_PREP: begin
        div_r <= (DIV_W'(yq) << 4) + (DIV_W'(yq) << 3);
      end
      ira_pkg::S_CHK: begin
        rem_r <= DIV_SAT;
        cnt_r <= '0;
        if (!in_band_r || y_nonpos) rate_r <= '0;
        else if (div_sat)           rate_r <= '1;
        else                        rate_r <= '0;
      end
      ira_pkg::S_DIV: begin
        rem_r  <= q_bit ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        rate_r <= {rate_r[RATE_W-2:0], q_bit};
        cnt_r  <= cnt_r + CNT_W'(1);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Accumulator update, done at the moment the result is loaded.
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] sum_r, sum_nxt, sum_base;
  logic             accumulating_r, accumulating_nxt;
  logic             done_r, done_nxt;
  logic             crossed;
  logic             done_base;
  logic [SUM_W:0]   sum_add;

  always_comb begin
    sum_base         = start_r ? '0 : sum_r;
    done_base        = start_r ? 1'b0 : done_r;
    accumulating_nxt = start_r || accumulating_r;
    sum_add          = {1'b0, sum_base} + (SUM_W+1)'(rate_r);
    sum_nxt          = sum_base;
    done_nxt         = done_base;
    crossed          = 1'b0;
    if (accumulating_nxt && !done_base) begin
      // The top carry of the sum means it passed the Q2 ceiling: saturate.
      sum_nxt  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      crossed  = CMP_W'(sum_nxt) > CMP_W'(threshold_r);
      done_nxt = crossed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r          <= '0;
      accumulating_r <= 1'b0;
      done_r         <= 1'b0;
    end else if (out_load) begin
      sum_r          <= sum_nxt;
      accumulating_r <= accumulating_nxt;
      done_r         <= done_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  logic [RATE_W+ira_pkg::RATE_OUT_W-1:0] rate_ext;
  logic [SUM_W+ira_pkg::SUM_OUT_W-1:0]   sum_ext;
  logic [ira_pkg::RATE_OUT_W-1:0]        out_rate_r;
  logic [ira_pkg::SUM_OUT_W-1:0]         out_sum_r;
  logic                                  out_done_r;
  logic                                  out_cross_r;
  logic                                  out_final_r;

  assign rate_ext = {{ira_pkg::RATE_OUT_W{1'b0}}, rate_r};
  assign sum_ext  = {{ira_pkg::SUM_OUT_W{1'b0}}, sum_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rate_r  <= rate_ext[ira_pkg::RATE_OUT_W-1:0];
      out_sum_r   <= sum_ext[ira_pkg::SUM_OUT_W-1:0];
      out_done_r  <= done_nxt;
      out_cross_r <= crossed;
      out_final_r <= final_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.hourly_rate     = out_rate_r;
  assign out_ch.accumulated     = out_sum_r;
  assign out_ch.incubation_done = out_done_r;
  assign out_ch.done_this_hour  = out_cross_r;
  assign out_ch.data_ended      = out_final_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `IRA_ASSERT_IMP(a_rem_below_div, clk, rst_n, state_r == ira_pkg::S_DIV, rem_r < div_r)
  `IRA_ASSERT_IMP(a_cross_sets_done, clk, rst_n, out_valid_r, !out_cross_r || out_done_r)
  `IRA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ch.ready)
  `IRA_ASSERT_NXT(a_load_once, clk, rst_n, out_load, out_valid_r && state_r == ira_pkg::S_IDLE)

endmodule
